@@ rtl/core/lce_pkg.sv @@
// Shared types and constants for the line comment extractor.
`timescale 1ns / 1ps

package lce_pkg;

  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharStar  = 8'h2A;
  localparam logic [7:0] CharQuote = 8'h22;
  localparam logic [7:0] CharNl    = 8'h0A;

  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutPtrW  = $clog2(OutDepth);
  localparam int unsigned OutCntW  = $clog2(OutDepth + 1);

  typedef enum logic [3:0] {
    MODE_CODE  = 4'b0001,
    MODE_BLOCK = 4'b0010,
    MODE_STR   = 4'b0100,
    MODE_LINE  = 4'b1000
  } mode_e;

  typedef struct packed {
    logic [7:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    mode_e      mode;
    logic       held_mark;
  } lex_state_t;

  typedef struct packed {
    lex_state_t next;
    logic [1:0] num_results;
    out_item_t  first;
    out_item_t  second;
  } step_t;

endpackage

@@ rtl/core/lce_stream_if.sv @@
// Valid/ready stream channel carrying one payload.
`timescale 1ns / 1ps

interface lce_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/lce_step.sv @@
// Combinational lexer step: next mode, held mark and results for one byte.
`timescale 1ns / 1ps

module lce_step (
  input  lce_pkg::lex_state_t cur_i,
  input  logic [7:0]          byte_i,
  output lce_pkg::step_t      step_o
);
  import lce_pkg::*;

  mode_e      mode_d;
  logic       mark_d;
  logic [1:0] num;
  logic [7:0] first_byte;

  always_comb begin
    mode_d     = cur_i.mode;
    mark_d     = cur_i.held_mark;
    num        = 2'd0;
    first_byte = byte_i;
    if (byte_i == CharNl) begin
      mark_d = 1'b0;
      if (cur_i.mode == MODE_LINE) begin
        mode_d = MODE_CODE;
        num    = 2'd1;
      end else if (cur_i.mode == MODE_STR) begin
        mode_d = MODE_CODE;
      end
    end else begin
      case (cur_i.mode)
        MODE_LINE: begin
          num = 2'd1;
        end
        MODE_STR: begin
          if (byte_i == CharQuote) begin
            mode_d = MODE_CODE;
          end
        end
        MODE_BLOCK: begin
          if (cur_i.held_mark && byte_i == CharSlash) begin
            mode_d = MODE_CODE;
            mark_d = 1'b0;
          end else begin
            mark_d = (byte_i == CharStar);
          end
        end
        default: begin
          mark_d = 1'b0;
          if (cur_i.held_mark && byte_i == CharStar) begin
            mode_d = MODE_BLOCK;
          end else if (cur_i.held_mark && byte_i == CharSlash) begin
            mode_d     = MODE_LINE;
            num        = 2'd2;
            first_byte = CharSlash;
          end else if (byte_i == CharSlash) begin
            mark_d = 1'b1;
          end else if (byte_i == CharQuote) begin
            mode_d = MODE_STR;
          end
        end
      endcase
    end
  end

  assign step_o.next.mode        = mode_d;
  assign step_o.next.held_mark   = mark_d;
  assign step_o.num_results      = num;
  assign step_o.first.out_byte   = first_byte;
  assign step_o.first.last_of_run = (num != 2'd2);
  assign step_o.second.out_byte  = CharSlash;
  assign step_o.second.last_of_run = 1'b1;

endmodule

@@ rtl/core/lce_out_fifo.sv @@
// Result queue: takes up to two results per cycle, hands out one.
`timescale 1ns / 1ps

module lce_out_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [1:0]            push_num_i,
  input  lce_pkg::out_item_t    push_first_i,
  input  lce_pkg::out_item_t    push_second_i,
  output logic                  room_o,
  lce_stream_if.source          out_o
);
  import lce_pkg::*;

  out_item_t              mem_q [OutDepth];
  logic [OutPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [OutPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [OutCntW-1:0]     count_q, count_d;
  logic                   pop;
  logic [OutPtrW-1:0]     wr_next;

  assign pop     = out_o.valid && out_o.ready;
  assign wr_next = wr_ptr_q + OutPtrW'(1);
  assign room_o  = (count_q <= OutCntW'(OutDepth - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + OutPtrW'(push_num_i);
    rd_ptr_d = pop ? rd_ptr_q + OutPtrW'(1) : rd_ptr_q;
    count_d  = count_q + OutCntW'(push_num_i) - OutCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push_first_i;
    end
    if (push_num_i == 2'd2) begin
      mem_q[wr_next] <= push_second_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign out_o.valid = (count_q != '0);
  assign out_o.data  = mem_q[rd_ptr_q];

endmodule

@@ rtl/core/line_comment_extractor.sv @@
// Top level of the line comment extractor.
// Scans C source text one byte per request and returns the text of every
// line comment: both slashes of the opening pair, each following byte of
// the line, then a newline byte. Block comments and quoted strings are
// skipped. A byte enters an input register, passes through combinational
// lexer logic and lands in a four-entry result queue, so a new byte is taken
// every cycle while the queue has room for two results. The output side
// drains one result per cycle while its ready is high; the second slash of
// an opening pair yields two results, so the queue can fill and stall input.
`timescale 1ns / 1ps

module line_comment_extractor (
  input  logic         clk_i,
  input  logic         rst_ni,
  lce_stream_if.sink   in_i,
  lce_stream_if.source out_o
);
  import lce_pkg::*;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  lex_state_t state_q;
  step_t      step;
  logic       room;
  logic       advance;
  logic [1:0] push_num;

  assign advance   = in_vld_q && room;
  assign in_i.ready = !in_vld_q || advance;
  assign push_num  = advance ? step.num_results : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.data.byte_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode      <= MODE_CODE;
      state_q.held_mark <= 1'b0;
    end else if (advance) begin
      state_q <= step.next;
    end
  end

  lce_step u_step (
    .cur_i  (state_q),
    .byte_i (in_byte_q),
    .step_o (step)
  );

  lce_out_fifo u_out_fifo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_num_i    (push_num),
    .push_first_i  (step.first),
    .push_second_i (step.second),
    .room_o        (room),
    .out_o         (out_o)
  );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the line comment extractor with random stalls on both channels.
`timescale 1ns / 1ps

module testbench;
  import lce_pkg::*;

  localparam int unsigned ByteTarget  = 750;
  localparam int unsigned IdlePct     = 23;
  localparam int unsigned QuietStart  = 300;
  localparam int unsigned QuietEnd    = 700;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned CycleLimit  = 200000;

  logic clk_i;
  logic rst_ni;

  lce_stream_if #(.payload_t(in_item_t))  in_if ();
  lce_stream_if #(.payload_t(out_item_t)) out_if ();

  line_comment_extractor i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic [7:0]  pending_q[$];
  out_item_t   comment_q[$];
  mode_e       lex_mode;
  logic        lex_held;
  int unsigned cycle_cnt;
  int unsigned err_cnt;
  logic        quiet;

  assign quiet = (cycle_cnt >= QuietStart) && (cycle_cnt < QuietEnd);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic logic [7:0] pick_byte(input bit no_nl);
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: b = CharSlash;
      1: b = CharStar;
      2: b = CharQuote;
      3: b = 8'h20;
      4, 5, 6: b = 8'h61 + 8'($urandom_range(0, 25));
      default: b = 8'($urandom_range(0, 255));
    endcase
    if (no_nl && b == CharNl) b = 8'h20;
    return b;
  endfunction

  task automatic push_run(input int unsigned lo, input int unsigned hi);
    int unsigned n;
    n = $urandom_range(lo, hi);
    repeat (n) pending_q.push_back(pick_byte(1'b1));
  endtask

  // Predict results of one accepted request
  task automatic scan_byte(input logic [7:0] b);
    if (b == CharNl) begin
      lex_held = 1'b0;
      if (lex_mode == MODE_LINE) begin
        lex_mode = MODE_CODE;
        comment_q.push_back('{out_byte: CharNl, last_of_run: 1'b1});
      end else if (lex_mode == MODE_STR) begin
        lex_mode = MODE_CODE;
      end
    end else begin
      case (lex_mode)
        MODE_LINE: begin
          comment_q.push_back('{out_byte: b, last_of_run: 1'b1});
        end
        MODE_STR: begin
          if (b == CharQuote) lex_mode = MODE_CODE;
        end
        MODE_BLOCK: begin
          if (lex_held && b == CharSlash) begin
            lex_mode = MODE_CODE;
            lex_held = 1'b0;
          end else begin
            lex_held = (b == CharStar);
          end
        end
        default: begin
          if (lex_held && b == CharStar) begin
            lex_held = 1'b0;
            lex_mode = MODE_BLOCK;
          end else if (lex_held && b == CharSlash) begin
            lex_held = 1'b0;
            lex_mode = MODE_LINE;
            comment_q.push_back('{out_byte: CharSlash, last_of_run: 1'b0});
            comment_q.push_back('{out_byte: CharSlash, last_of_run: 1'b1});
          end else begin
            lex_held = (b == CharSlash);
            if (b == CharQuote) lex_mode = MODE_STR;
          end
        end
      endcase
    end
  endtask

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) scan_byte(in_if.data.byte_in);
      if (pending_q.size() != 0 && (quiet || $urandom_range(0, 99) >= IdlePct)) begin
        in_if.valid <= 1'b1;
        in_if.data  <= '{byte_in: pending_q.pop_front()};
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (comment_q.size() == 0) begin
          $display("%0t: unexpected result: expected none actual out_byte %h last_of_run %b",
                   $time, out_if.data.out_byte, out_if.data.last_of_run);
          err_cnt = err_cnt + 1;
        end else begin
          if (out_if.data.out_byte !== comment_q[0].out_byte) begin
            $display("%0t: out_byte mismatch: expected %h actual %h",
                     $time, comment_q[0].out_byte, out_if.data.out_byte);
            err_cnt = err_cnt + 1;
          end
          if (out_if.data.last_of_run !== comment_q[0].last_of_run) begin
            $display("%0t: last_of_run mismatch: expected %b actual %b",
                     $time, comment_q[0].last_of_run, out_if.data.last_of_run);
            err_cnt = err_cnt + 1;
          end
          void'(comment_q.pop_front());
        end
      end
      out_if.ready <= quiet || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) @(posedge clk_i);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic [7:0] directed[] = '{
      8'h00, 8'hFF, CharNl,
      CharSlash, CharSlash, 8'h00, 8'hFF, CharQuote, CharNl,
      CharSlash, CharStar, CharStar, CharStar, CharNl, CharStar, CharSlash,
      CharQuote, CharQuote, CharSlash, CharQuote, CharSlash, CharNl,
      CharSlash, CharNl, CharSlash, CharNl
    };
    int unsigned r;
    rst_ni       = 1'b0;
    cycle_cnt    = 0;
    err_cnt      = 0;
    lex_mode     = MODE_CODE;
    lex_held     = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;

    foreach (directed[k]) pending_q.push_back(directed[k]);
    // Exercise an unterminated string across a line break and a split close inside a block
    pending_q.push_back(CharQuote);
    pending_q.push_back(8'h41);
    pending_q.push_back(CharNl);
    pending_q.push_back(CharSlash);
    pending_q.push_back(CharStar);
    pending_q.push_back(CharStar);
    pending_q.push_back(CharNl);
    pending_q.push_back(CharSlash);
    pending_q.push_back(CharStar);
    pending_q.push_back(CharSlash);

    while (pending_q.size() < ByteTarget) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        push_run(1, 6);
      end else if (r < 35) begin
        pending_q.push_back(CharQuote);
        push_run(0, 5);
        pending_q.push_back(CharQuote);
      end else if (r < 50) begin
        pending_q.push_back(CharSlash);
        pending_q.push_back(CharStar);
        push_run(0, 6);
        if ($urandom_range(0, 3) == 0) pending_q.push_back(CharNl);
        pending_q.push_back(CharStar);
        pending_q.push_back(CharSlash);
      end else if (r < 70) begin
        pending_q.push_back(CharSlash);
        pending_q.push_back(CharSlash);
        push_run(0, 10);
        pending_q.push_back(CharNl);
      end else if (r < 85) begin
        pending_q.push_back(CharNl);
      end else begin
        repeat ($urandom_range(1, 4)) pending_q.push_back(8'($urandom_range(0, 255)));
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || in_if.valid || comment_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_cnt == 0 && comment_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
